// ===== design/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear RGBA scaler package
// Shared field widths, register indexes, item modes and the pixel type.
// ----------------------------------------------------------------------------
package brs_pkg;

   // Field widths of the item and the configuration port.
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 4;
   localparam int COORD_W    = 12;
   localparam int SRC_SIZE_W = 9;
   localparam int DST_SIZE_W = 13;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Item modes.
   typedef enum logic {
      MODE_WRITE   = 1'b0,
      MODE_REQUEST = 1'b1
   } mode_type;

   // Register indexes, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_SOURCE_WIDTH  = 2'd0,
      REG_SOURCE_HEIGHT = 2'd1,
      REG_TARGET_WIDTH  = 2'd2,
      REG_TARGET_HEIGHT = 2'd3
   } reg_index_type;

   // One RGBA8 pixel: channel 0 is red, then green, blue and alpha.
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_type;

endpackage

// ===== design/brs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/brs_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Pipelined two-lane divider
// Restoring division, one quotient bit per stage, for the column and row
// lanes side by side. The numerator is shifted up by FRAC_W bits so the
// quotient carries INT_W integer bits and FRAC_W fraction bits.
// ----------------------------------------------------------------------------
module brs_div_pipe #(
   parameter int NUM_W  = 21,
   parameter int DEN_W  = 13,
   parameter int INT_W  = 8,
   parameter int FRAC_W = 16,
   parameter int TAG_W  = 1,
   localparam int QW = INT_W + FRAC_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [TAG_W-1:0] in_tag,
   input  logic [NUM_W-1:0] in_num_x,
   input  logic [NUM_W-1:0] in_num_y,
   input  logic [DEN_W-1:0] den_x,
   input  logic [DEN_W-1:0] den_y,
   output logic             out_valid,
   output logic [TAG_W-1:0] out_tag,
   output logic [QW-1:0]    out_quo_x,
   output logic [QW-1:0]    out_quo_y
);

   logic [QW-1:0]    valid_ff;
   logic [QW-1:0]    valid_in;
   logic [DEN_W-1:0] rem_x_ff  [QW];
   logic [DEN_W-1:0] rem_x_in  [QW];
   logic [DEN_W-1:0] rem_y_ff  [QW];
   logic [DEN_W-1:0] rem_y_in  [QW];
   logic [QW-1:0]    work_x_ff [QW];
   logic [QW-1:0]    work_x_in [QW];
   logic [QW-1:0]    work_y_ff [QW];
   logic [QW-1:0]    work_y_in [QW];
   logic [TAG_W-1:0] tag_ff    [QW];
   logic [TAG_W-1:0] tag_in    [QW];

   // One restoring step: bring in the next numerator bit, subtract when it
   // fits, and shift the quotient bit in at the bottom of the work word.
   function automatic logic [DEN_W+QW-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                     input logic [QW-1:0] work,
                                                     input logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           fits;
      trial = {rem, work[QW-1]};
      diff  = trial - {1'b0, den};
      fits  = (trial >= {1'b0, den});
      return {(fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0]), work[QW-2:0], fits};
   endfunction

   // Stage inputs; the first stage seeds the remainder with the numerator
   // bits above the quotient range.
   always_comb begin
      valid_in = {valid_ff[QW-2:0], in_valid};
      for (int s = 0; s < QW; s++) begin
         if (s == 0) begin
            {rem_x_in[s], work_x_in[s]} =
               div_step(DEN_W'(in_num_x >> INT_W), {in_num_x[INT_W-1:0], FRAC_W'(0)}, den_x);
            {rem_y_in[s], work_y_in[s]} =
               div_step(DEN_W'(in_num_y >> INT_W), {in_num_y[INT_W-1:0], FRAC_W'(0)}, den_y);
            tag_in[s] = in_tag;
         end else begin
            {rem_x_in[s], work_x_in[s]} = div_step(rem_x_ff[s-1], work_x_ff[s-1], den_x);
            {rem_y_in[s], work_y_in[s]} = div_step(rem_y_ff[s-1], work_y_ff[s-1], den_y);
            tag_in[s] = tag_ff[s-1];
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_x_ff  <= rem_x_in;
         rem_y_ff  <= rem_y_in;
         work_x_ff <= work_x_in;
         work_y_ff <= work_y_in;
         tag_ff    <= tag_in;
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];
   assign out_quo_x = work_x_ff[QW-1];
   assign out_quo_y = work_y_ff[QW-1];

endmodule

// ===== design/bilinear_rgba_image_scaler.sv =====
// ----------------------------------------------------------------------------
// Bilinear RGBA image scaler
// Stores an RGBA8 source frame and returns bilinear destination pixels.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while req_stall is low, writes
// and requests alike. A write item produces no result; a request's result
// comes from the output register. The divider resolves one quotient bit of
// the source position per pipeline stage. A stalled output first holds its
// result in the output register; the input stalls only once a second result
// waits in the stage behind it, and items flow again in the cycle the output
// is taken. The frame is split into four banks by column and row parity so
// the four neighbors of a request are read in the same cycle. Frame contents
// are undefined after reset until written; reading a pixel that was never
// written gives an undefined result.
module bilinear_rgba_image_scaler #(
   parameter int MAX_SOURCE_WIDTH  = 256,
   parameter int MAX_SOURCE_HEIGHT = 256,
   parameter int FRACTION_BITS     = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Item input.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [brs_pkg::COORD_W-1:0]       req_coord_x,
   input  logic [brs_pkg::COORD_W-1:0]       req_coord_y,
   input  logic [brs_pkg::CHAN_W-1:0]        req_in_red,
   input  logic [brs_pkg::CHAN_W-1:0]        req_in_green,
   input  logic [brs_pkg::CHAN_W-1:0]        req_in_blue,
   input  logic [brs_pkg::CHAN_W-1:0]        req_in_alpha,
   // Result output.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [brs_pkg::CHAN_W-1:0]        rsp_out_red,
   output logic [brs_pkg::CHAN_W-1:0]        rsp_out_green,
   output logic [brs_pkg::CHAN_W-1:0]        rsp_out_blue,
   output logic [brs_pkg::CHAN_W-1:0]        rsp_out_alpha,
   output logic                              rsp_bad_coordinate,
   // Configuration port.
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [brs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [brs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [brs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   import brs_pkg::*;

   localparam int SXW        = $clog2(MAX_SOURCE_WIDTH);
   localparam int SYW        = $clog2(MAX_SOURCE_HEIGHT);
   localparam int INT_W      = (SXW > SYW) ? SXW : SYW;
   localparam int QW         = INT_W + FRACTION_BITS;
   localparam int PROD_W     = COORD_W + SRC_SIZE_W;
   localparam int CMP_W      = DST_SIZE_W + 1;
   localparam int BANK_W     = (MAX_SOURCE_WIDTH + 1) / 2;
   localparam int BANK_H     = (MAX_SOURCE_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = BANK_W * BANK_H;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int NUM_BANKS  = 4;
   localparam int WT_W       = FRACTION_BITS + 1;
   localparam int PRD_W      = CHAN_W + WT_W;
   localparam int HOR_W      = CHAN_W + FRACTION_BITS;
   localparam int VERT_W     = HOR_W + WT_W;
   localparam int PIX_W      = $bits(pixel_type);

   // Item information that rides along the divider.
   typedef struct packed {
      mode_type           mode;
      logic               bad;
      logic               wr_ok;
      logic [SXW-1:0]     wx;
      logic [SYW-1:0]     wy;
      pixel_type          pixel;
   } tag_type;

   localparam int TAG_W = $bits(tag_type);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [SRC_SIZE_W-1:0] src_width_ff;
   logic [SRC_SIZE_W-1:0] src_height_ff;
   logic [DST_SIZE_W-1:0] dst_width_ff;
   logic [DST_SIZE_W-1:0] dst_height_ff;
   logic [SRC_SIZE_W-1:0] sw;
   logic [SRC_SIZE_W-1:0] sh;
   logic [DST_SIZE_W-1:0] dw;
   logic [DST_SIZE_W-1:0] dh;

   assign pready = 1'b1;

   // Register writes complete in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_SIZE_W'(256);
         src_height_ff <= SRC_SIZE_W'(256);
         dst_width_ff  <= DST_SIZE_W'(256);
         dst_height_ff <= DST_SIZE_W'(256);
      end else if (psel && penable && pwrite) begin
         unique case (reg_index_type'(paddr[3:2]))
            REG_SOURCE_WIDTH:  src_width_ff  <= pwdata[SRC_SIZE_W-1:0];
            REG_SOURCE_HEIGHT: src_height_ff <= pwdata[SRC_SIZE_W-1:0];
            REG_TARGET_WIDTH:  dst_width_ff  <= pwdata[DST_SIZE_W-1:0];
            REG_TARGET_HEIGHT: dst_height_ff <= pwdata[DST_SIZE_W-1:0];
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (reg_index_type'(paddr[3:2]))
         REG_SOURCE_WIDTH:  prdata = CSR_DATA_W'(src_width_ff);
         REG_SOURCE_HEIGHT: prdata = CSR_DATA_W'(src_height_ff);
         REG_TARGET_WIDTH:  prdata = CSR_DATA_W'(dst_width_ff);
         REG_TARGET_HEIGHT: prdata = CSR_DATA_W'(dst_height_ff);
      endcase
   end

   // Effective sizes: zero acts as one, source sizes are capped at the frame.
   always_comb begin
      if (src_width_ff == '0) begin
         sw = SRC_SIZE_W'(1);
      end else if (32'(src_width_ff) > MAX_SOURCE_WIDTH) begin
         sw = SRC_SIZE_W'(MAX_SOURCE_WIDTH);
      end else begin
         sw = src_width_ff;
      end
      if (src_height_ff == '0) begin
         sh = SRC_SIZE_W'(1);
      end else if (32'(src_height_ff) > MAX_SOURCE_HEIGHT) begin
         sh = SRC_SIZE_W'(MAX_SOURCE_HEIGHT);
      end else begin
         sh = src_height_ff;
      end
      dw = (dst_width_ff == '0) ? DST_SIZE_W'(1) : dst_width_ff;
      dh = (dst_height_ff == '0) ? DST_SIZE_W'(1) : dst_height_ff;
   end

   // ------------------------------------------------------------------
   // Pipeline control: everything moves unless the last stage holds an
   // item and the output register is full and stalled.
   // ------------------------------------------------------------------
   logic v_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = !v_valid_ff || out_free;
   assign req_stall = !advance;

   // ------------------------------------------------------------------
   // Stage M: scale the coordinates by the source size.
   // ------------------------------------------------------------------
   logic              m_valid_ff;
   logic [PROD_W-1:0] m_prod_x_ff;
   logic [PROD_W-1:0] m_prod_y_ff;
   tag_type           m_tag_ff;
   tag_type           m_tag_in;

   always_comb begin
      m_tag_in.mode  = mode_type'(req_mode);
      m_tag_in.bad   = (DST_SIZE_W'(req_coord_x) >= dw) || (DST_SIZE_W'(req_coord_y) >= dh);
      m_tag_in.wr_ok = (CMP_W'(req_coord_x) < CMP_W'(sw)) && (CMP_W'(req_coord_y) < CMP_W'(sh));
      m_tag_in.wx    = req_coord_x[SXW-1:0];
      m_tag_in.wy    = req_coord_y[SYW-1:0];
      m_tag_in.pixel = {req_in_alpha, req_in_blue, req_in_green, req_in_red};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_prod_x_ff <= PROD_W'(req_coord_x) * PROD_W'(sw);
         m_prod_y_ff <= PROD_W'(req_coord_y) * PROD_W'(sh);
         m_tag_ff    <= m_tag_in;
      end
   end

   // ------------------------------------------------------------------
   // Divider: source position with its fraction.
   // ------------------------------------------------------------------
   logic          d_valid;
   tag_type       d_tag;
   logic [QW-1:0] d_qx;
   logic [QW-1:0] d_qy;

   brs_div_pipe #(
      .NUM_W  (PROD_W),
      .DEN_W  (DST_SIZE_W),
      .INT_W  (INT_W),
      .FRAC_W (FRACTION_BITS),
      .TAG_W  (TAG_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m_valid_ff),
      .in_tag    (m_tag_ff),
      .in_num_x  (m_prod_x_ff),
      .in_num_y  (m_prod_y_ff),
      .den_x     (dw),
      .den_y     (dh),
      .out_valid (d_valid),
      .out_tag   (d_tag),
      .out_quo_x (d_qx),
      .out_quo_y (d_qy)
   );

   // ------------------------------------------------------------------
   // Stage A: bank addresses, frame writes and neighbor reads.
   // ------------------------------------------------------------------
   logic [SXW-1:0]           sx;
   logic [SYW-1:0]           sy;
   logic [FRACTION_BITS-1:0] fx;
   logic [FRACTION_BITS-1:0] fy;
   logic [SXW:0]             sx_next;
   logic [SYW:0]             sy_next;
   logic                     ex_ok;
   logic                     ey_ok;
   logic [SXW:0]             bank_col [NUM_BANKS];
   logic [SYW:0]             bank_row [NUM_BANKS];
   logic [AW-1:0]            rd_addr  [NUM_BANKS];
   logic [NUM_BANKS-1:0]     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [PIX_W-1:0]         ram_q    [NUM_BANKS];

   always_comb begin
      sx      = d_qx[FRACTION_BITS +: SXW];
      sy      = d_qy[FRACTION_BITS +: SYW];
      fx      = d_qx[FRACTION_BITS-1:0];
      fy      = d_qy[FRACTION_BITS-1:0];
      sx_next = {1'b0, sx} + (SXW+1)'(1);
      sy_next = {1'b0, sy} + (SYW+1)'(1);
      ex_ok   = (CMP_W'(sx_next) < CMP_W'(sw));
      ey_ok   = (CMP_W'(sy_next) < CMP_W'(sh));
      wr_addr = AW'(32'(d_tag.wy >> 1) * BANK_W + 32'(d_tag.wx >> 1));
      // Bank index is row parity then column parity; each bank holds the
      // one neighbor whose parities match it.
      for (int b = 0; b < NUM_BANKS; b++) begin
         bank_col[b] = (sx[0] == b[0]) ? {1'b0, sx} : sx_next;
         bank_row[b] = (sy[0] == b[1]) ? {1'b0, sy} : sy_next;
         rd_addr[b]  = AW'(32'(bank_row[b] >> 1) * BANK_W + 32'(bank_col[b] >> 1));
         wr_en[b]    = advance && d_valid && (d_tag.mode == MODE_WRITE) && d_tag.wr_ok &&
                       (d_tag.wx[0] == b[0]) && (d_tag.wy[0] == b[1]);
      end
   end

   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
      brs_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr),
         .wr_data (d_tag.pixel),
         .rd_en   (advance),
         .rd_addr (rd_addr[g]),
         .rd_data (ram_q[g])
      );
   end

   // ------------------------------------------------------------------
   // Stage R: neighbor data arrives; only requests go on from here.
   // ------------------------------------------------------------------
   logic                     r_valid_ff;
   logic                     r_bad_ff;
   logic                     r_ex_ok_ff;
   logic                     r_ey_ok_ff;
   logic                     r_sx0_ff;
   logic                     r_sy0_ff;
   logic [FRACTION_BITS-1:0] r_fx_ff;
   logic [FRACTION_BITS-1:0] r_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (advance) begin
         r_valid_ff <= d_valid && (d_tag.mode == MODE_REQUEST);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_bad_ff   <= d_tag.bad;
         r_ex_ok_ff <= ex_ok;
         r_ey_ok_ff <= ey_ok;
         r_sx0_ff   <= sx[0];
         r_sy0_ff   <= sy[0];
         r_fx_ff    <= fx;
         r_fy_ff    <= fy;
      end
   end

   // Neighbor selection with edge replacement, then the horizontal blend.
   pixel_type         p00;
   pixel_type         p10;
   pixel_type         p01;
   pixel_type         p11;
   pixel_type         q10;
   pixel_type         q01;
   pixel_type         q11;
   logic [WT_W-1:0]   wx_a;
   logic [WT_W-1:0]   wx_b;
   logic [HOR_W-1:0]  h_top_in [NUM_CHAN];
   logic [HOR_W-1:0]  h_bot_in [NUM_CHAN];

   always_comb begin
      p00  = ram_q[{r_sy0_ff, r_sx0_ff}];
      q10  = ram_q[{r_sy0_ff, !r_sx0_ff}];
      q01  = ram_q[{!r_sy0_ff, r_sx0_ff}];
      q11  = ram_q[{!r_sy0_ff, !r_sx0_ff}];
      p10  = r_ex_ok_ff ? q10 : p00;
      p01  = r_ey_ok_ff ? q01 : p00;
      if (r_ex_ok_ff && r_ey_ok_ff) begin
         p11 = q11;
      end else if (r_ex_ok_ff) begin
         p11 = q10;
      end else if (r_ey_ok_ff) begin
         p11 = q01;
      end else begin
         p11 = p00;
      end
      wx_a = {1'b1, FRACTION_BITS'(0)} - {1'b0, r_fx_ff};
      wx_b = {1'b0, r_fx_ff};
      for (int c = 0; c < NUM_CHAN; c++) begin
         h_top_in[c] = HOR_W'(PRD_W'(p00[c]) * PRD_W'(wx_a) + PRD_W'(p10[c]) * PRD_W'(wx_b));
         h_bot_in[c] = HOR_W'(PRD_W'(p01[c]) * PRD_W'(wx_a) + PRD_W'(p11[c]) * PRD_W'(wx_b));
      end
   end

   // ------------------------------------------------------------------
   // Stage H: horizontal results.
   // ------------------------------------------------------------------
   logic                     h_valid_ff;
   logic                     h_bad_ff;
   logic [FRACTION_BITS-1:0] h_fy_ff;
   logic [HOR_W-1:0]         h_top_ff [NUM_CHAN];
   logic [HOR_W-1:0]         h_bot_ff [NUM_CHAN];

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (advance) begin
         h_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h_bad_ff <= r_bad_ff;
         h_fy_ff  <= r_fy_ff;
         h_top_ff <= h_top_in;
         h_bot_ff <= h_bot_in;
      end
   end

   // Vertical weights and products.
   logic [WT_W-1:0]   wy_a;
   logic [WT_W-1:0]   wy_b;
   logic [VERT_W-1:0] v_mt_in [NUM_CHAN];
   logic [VERT_W-1:0] v_mb_in [NUM_CHAN];

   always_comb begin
      wy_a = {1'b1, FRACTION_BITS'(0)} - {1'b0, h_fy_ff};
      wy_b = {1'b0, h_fy_ff};
      for (int c = 0; c < NUM_CHAN; c++) begin
         v_mt_in[c] = VERT_W'(h_top_ff[c]) * VERT_W'(wy_a);
         v_mb_in[c] = VERT_W'(h_bot_ff[c]) * VERT_W'(wy_b);
      end
   end

   // ------------------------------------------------------------------
   // Stage V: vertical products.
   // ------------------------------------------------------------------
   logic              v_bad_ff;
   logic [VERT_W-1:0] v_mt_ff [NUM_CHAN];
   logic [VERT_W-1:0] v_mb_ff [NUM_CHAN];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
      end else if (advance) begin
         v_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v_bad_ff <= h_bad_ff;
         v_mt_ff  <= v_mt_in;
         v_mb_ff  <= v_mb_in;
      end
   end

   // Final sum and truncation; an out-of-range request reads as zero.
   logic [VERT_W-1:0] v_sum [NUM_CHAN];
   pixel_type         rsp_pixel_in;

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         v_sum[c]        = v_mt_ff[c] + v_mb_ff[c];
         rsp_pixel_in[c] = v_bad_ff ? CHAN_W'(0) : v_sum[c][2*FRACTION_BITS +: CHAN_W];
      end
   end

   // ------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------
   pixel_type rsp_pixel_ff;
   logic      rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= v_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && v_valid_ff) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_bad_ff   <= v_bad_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_red        = rsp_pixel_ff[0];
   assign rsp_out_green      = rsp_pixel_ff[1];
   assign rsp_out_blue       = rsp_pixel_ff[2];
   assign rsp_out_alpha      = rsp_pixel_ff[3];
   assign rsp_bad_coordinate = rsp_bad_ff;

`ifndef SYNTHESIS
   // The divider must place an in-range request inside the source frame.
   a_position_in_frame: assert property (@(posedge clock) disable iff (reset)
      (d_valid && (d_tag.mode == MODE_REQUEST) && !d_tag.bad) |->
      ((CMP_W'(sx) < CMP_W'(sw)) && (CMP_W'(sy) < CMP_W'(sh))))
      else $error("source position outside the frame");

   // Reset empties the back of the pipeline and the output register.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !v_valid_ff && !h_valid_ff))
      else $error("pipeline not empty after reset");

   // A result flagged as a bad coordinate carries zero channels.
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_pixel_ff == '0))
      else $error("bad coordinate result with nonzero channels");
`endif

endmodule

// ===== tb/sv/tb_bilinear_rgba_image_scaler.sv =====
// ----------------------------------------------------------------------------
// Bilinear RGBA image scaler testbench
// Loads source frames through write items, requests destination pixels under
// several frame and target sizes, and checks every result against an
// in-bench bilinear predictor while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bilinear_rgba_image_scaler;

   import brs_pkg::*;

   // Expected result of one request.
   typedef struct {
      pixel_type color;
      logic      bad;
   } scaled_pixel_type;

   // Tracks the frame and sizes, predicts each request and compares results.
   class scaler_scoreboard;
      pixel_type        frame [65536];
      int unsigned      src_w, src_h, dst_w, dst_h;
      scaled_pixel_type expected_q [$];
      int unsigned      mismatches;
      int unsigned      results_seen;

      function new();
         src_w = 256;
         src_h = 256;
         dst_w = 256;
         dst_h = 256;
         mismatches = 0;
         results_seen = 0;
      endfunction

      // Registers hold raw values; zero acts as one and source sizes cap at 256.
      function int unsigned eff_size(int unsigned v, int unsigned maxv);
         if (v == 0) return 1;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function int unsigned src_w_eff();
         return eff_size(src_w, 256);
      endfunction

      function int unsigned src_h_eff();
         return eff_size(src_h, 256);
      endfunction

      function int unsigned dst_w_eff();
         return eff_size(dst_w, 8191);
      endfunction

      function int unsigned dst_h_eff();
         return eff_size(dst_h, 8191);
      endfunction

      function void set_reg(reg_index_type idx, int unsigned v);
         case (idx)
            REG_SOURCE_WIDTH:  src_w = v & 'h1FF;
            REG_SOURCE_HEIGHT: src_h = v & 'h1FF;
            REG_TARGET_WIDTH:  dst_w = v & 'h1FFF;
            REG_TARGET_HEIGHT: dst_h = v & 'h1FFF;
         endcase
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Notes an accepted item: writes update the frame, requests are predicted.
      function void note_item(mode_type mode, int unsigned x, int unsigned y, pixel_type pix);
         longint unsigned  sw, sh, dw, dh, sx, sy, fx, fy, ex, ey;
         longint unsigned  top, bot, v;
         pixel_type        p00, p10, p01, p11;
         scaled_pixel_type r;
         sw = src_w_eff();
         sh = src_h_eff();
         dw = dst_w_eff();
         dh = dst_h_eff();
         if (mode == MODE_WRITE) begin
            if (x < sw && y < sh) frame[y * 256 + x] = pix;
            return;
         end
         r.color = '0;
         r.bad = 1'b0;
         if (x >= dw || y >= dh) begin
            r.bad = 1'b1;
         end else begin
            sx = (x * sw) / dw;
            sy = (y * sh) / dh;
            fx = (((x * sw) % dw) << 16) / dw;
            fy = (((y * sh) % dh) << 16) / dh;
            p00 = frame[sy * 256 + sx];
            p10 = (sx + 1 < sw) ? frame[sy * 256 + sx + 1] : p00;
            p01 = (sy + 1 < sh) ? frame[(sy + 1) * 256 + sx] : p00;
            ex = (sx + 1 < sw) ? sx + 1 : sw - 1;
            ey = (sy + 1 < sh) ? sy + 1 : sh - 1;
            p11 = frame[ey * 256 + ex];
            // Blend along x, then along y, and drop the fraction.
            for (int c = 0; c < NUM_CHAN; c++) begin
               top = p00[c] * (65536 - fx) + p10[c] * fx;
               bot = p01[c] * (65536 - fx) + p11[c] * fx;
               v = (top * (65536 - fy) + bot * fy) >> 32;
               r.color[c] = v[7:0];
            end
         end
         expected_q.push_back(r);
      endfunction

      // Compares one accepted result with the oldest prediction.
      function void check_result(pixel_type color, logic bad);
         scaled_pixel_type e;
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result color=%h bad=%b", color, bad);
            return;
         end
         e = expected_q.pop_front();
         if (e.color !== color || e.bad !== bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d expected color=%h bad=%b, got color=%h bad=%b",
                        results_seen, e.color, e.bad, color, bad);
         end
      endfunction
   endclass

   localparam int DRAIN_CYCLES = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = 1'b0;
   logic [COORD_W-1:0]    req_coord_x = '0;
   logic [COORD_W-1:0]    req_coord_y = '0;
   logic [CHAN_W-1:0]     req_in_red = '0;
   logic [CHAN_W-1:0]     req_in_green = '0;
   logic [CHAN_W-1:0]     req_in_blue = '0;
   logic [CHAN_W-1:0]     req_in_alpha = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAN_W-1:0]     rsp_out_red;
   logic [CHAN_W-1:0]     rsp_out_green;
   logic [CHAN_W-1:0]     rsp_out_blue;
   logic [CHAN_W-1:0]     rsp_out_alpha;
   logic                  rsp_bad_coordinate;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   scaler_scoreboard scaler_sb = new();
   int unsigned      sender_idle_pct = 0;
   int unsigned      receiver_stall_pct = 0;
   int unsigned      items_sent = 0;
   int unsigned      requests_sent = 0;

   bilinear_rgba_image_scaler i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_in_red(req_in_red), .req_in_green(req_in_green),
      .req_in_blue(req_in_blue), .req_in_alpha(req_in_alpha),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_out_alpha(rsp_out_alpha),
      .rsp_bad_coordinate(rsp_bad_coordinate),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   // Random receiver stall.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         scaler_sb.check_result({rsp_out_alpha, rsp_out_blue, rsp_out_green, rsp_out_red},
                                rsp_bad_coordinate);
   end

   // Sends one item, with random idle cycles ahead of it.
   task automatic send_item(mode_type mode, int unsigned x, int unsigned y, pixel_type pix);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_coord_x  <= x[COORD_W-1:0];
      req_coord_y  <= y[COORD_W-1:0];
      req_in_red   <= pix[0];
      req_in_green <= pix[1];
      req_in_blue  <= pix[2];
      req_in_alpha <= pix[3];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scaler_sb.note_item(mode, x, y, pix);
      items_sent++;
      if (mode == MODE_REQUEST) requests_sent++;
   endtask

   // Waits until every predicted result has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scaler_sb.pending() != 0) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle.
   task automatic csr_write(reg_index_type idx, int unsigned v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      scaler_sb.set_reg(idx, v);
   endtask

   function automatic pixel_type random_pixel();
      return pixel_type'($urandom);
   endfunction

   // Writes every pixel of the active source frame so no read sees stale memory.
   task automatic fill_frame();
      for (int y = 0; y < scaler_sb.src_h_eff(); y++)
         for (int x = 0; x < scaler_sb.src_w_eff(); x++)
            send_item(MODE_WRITE, x, y, random_pixel());
   endtask

   // Mostly in-range requests, some outside the target, some writes.
   task automatic random_items(int n);
      int unsigned xmax, ymax, pick;
      xmax = (scaler_sb.dst_w_eff() > 4096) ? 4095 : scaler_sb.dst_w_eff() - 1;
      ymax = (scaler_sb.dst_h_eff() > 4096) ? 4095 : scaler_sb.dst_h_eff() - 1;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 65)
            send_item(MODE_REQUEST, $urandom_range(xmax), $urandom_range(ymax), '0);
         else if (pick < 75)
            send_item(MODE_REQUEST, $urandom_range(4095), $urandom_range(4095), random_pixel());
         else if (pick < 93)
            send_item(MODE_WRITE, $urandom_range(scaler_sb.src_w_eff() - 1),
                      $urandom_range(scaler_sb.src_h_eff() - 1), random_pixel());
         else
            send_item(MODE_WRITE, $urandom_range(4095), $urandom_range(4095), random_pixel());
      end
   endtask

   // Phase settings, extremes and out-of-range register values among them.
   int unsigned phase_sw [6] = '{4, 0, 40, 1, 5, 16};
   int unsigned phase_sh [6] = '{3, 1, 1, 300, 7, 4};
   int unsigned phase_tw [6] = '{7, 0, 4096, 2, 3, 37};
   int unsigned phase_th [6] = '{5, 1, 3, 8191, 2, 11};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 6; p++) begin
         // Receiver stalls heavily first, then the sender idles, then neither.
         sender_idle_pct    = (p < 2) ? 24 : (p < 4) ? 79 : 0;
         receiver_stall_pct = (p < 2) ? 79 : (p < 4) ? 24 : 0;
         drain_results();
         repeat (DRAIN_CYCLES) @(posedge clock);
         csr_write(REG_SOURCE_WIDTH, phase_sw[p]);
         csr_write(REG_SOURCE_HEIGHT, phase_sh[p]);
         csr_write(REG_TARGET_WIDTH, phase_tw[p]);
         csr_write(REG_TARGET_HEIGHT, phase_th[p]);
         fill_frame();
         if (p == 0) begin
            // Corners, requests past each edge and writes outside the frame.
            send_item(MODE_REQUEST, 0, 0, '0);
            send_item(MODE_REQUEST, 6, 4, '0);
            send_item(MODE_REQUEST, 3, 2, '0);
            send_item(MODE_REQUEST, 7, 0, '0);
            send_item(MODE_REQUEST, 0, 5, '0);
            send_item(MODE_REQUEST, 4095, 4095, '1);
            send_item(MODE_WRITE, 4, 0, '1);
            send_item(MODE_WRITE, 0, 3, '1);
            send_item(MODE_WRITE, 4095, 4095, '1);
            send_item(MODE_WRITE, 0, 0, '0);
            send_item(MODE_WRITE, 1, 0, '1);
            send_item(MODE_WRITE, 3, 2, '1);
            send_item(MODE_WRITE, 2, 1, '0);
            send_item(MODE_REQUEST, 1, 0, '0);
            send_item(MODE_REQUEST, 1, 1, '0);
            send_item(MODE_REQUEST, 6, 4, '0);
            send_item(MODE_REQUEST, 5, 3, '0);
            // Hold off until the pipeline is empty, then resume.
            drain_results();
         end
         random_items(38);
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d items (%0d requests) over six frame and target size settings,",
               items_sent, requests_sent);
      $display("with idle and stall on each side; %0d results checked, %0d mismatches.",
               scaler_sb.results_seen, scaler_sb.mismatches);
      if (scaler_sb.mismatches == 0 && scaler_sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #(12 * 2000000);
      $display("Timeout with %0d results outstanding.", scaler_sb.pending());
      $display("== FAIL ==");
      $finish;
   end

endmodule
